/* src/arcm_pkg.sv */
`default_nettype none
package arcm_pkg;

    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY1_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY1_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY2_LOW  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY2_HIGH = 2'd3;
    localparam int unsigned FINAL_ROUNDS = 10;

    typedef logic [127:0] blk_t;

    // Byte-wide slot of a 128-bit value; byte k at bits 8k+7:8k.
    function automatic logic [7:0] gf_dbl(input logic [7:0] a);
        gf_dbl = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] s;
        unique case (x)
            8'h00: s=8'h63; 8'h01: s=8'h7c; 8'h02: s=8'h77; 8'h03: s=8'h7b;
            8'h04: s=8'hf2; 8'h05: s=8'h6b; 8'h06: s=8'h6f; 8'h07: s=8'hc5;
            8'h08: s=8'h30; 8'h09: s=8'h01; 8'h0a: s=8'h67; 8'h0b: s=8'h2b;
            8'h0c: s=8'hfe; 8'h0d: s=8'hd7; 8'h0e: s=8'hab; 8'h0f: s=8'h76;
            8'h10: s=8'hca; 8'h11: s=8'h82; 8'h12: s=8'hc9; 8'h13: s=8'h7d;
            8'h14: s=8'hfa; 8'h15: s=8'h59; 8'h16: s=8'h47; 8'h17: s=8'hf0;
            8'h18: s=8'had; 8'h19: s=8'hd4; 8'h1a: s=8'ha2; 8'h1b: s=8'haf;
            8'h1c: s=8'h9c; 8'h1d: s=8'ha4; 8'h1e: s=8'h72; 8'h1f: s=8'hc0;
            8'h20: s=8'hb7; 8'h21: s=8'hfd; 8'h22: s=8'h93; 8'h23: s=8'h26;
            8'h24: s=8'h36; 8'h25: s=8'h3f; 8'h26: s=8'hf7; 8'h27: s=8'hcc;
            8'h28: s=8'h34; 8'h29: s=8'ha5; 8'h2a: s=8'he5; 8'h2b: s=8'hf1;
            8'h2c: s=8'h71; 8'h2d: s=8'hd8; 8'h2e: s=8'h31; 8'h2f: s=8'h15;
            8'h30: s=8'h04; 8'h31: s=8'hc7; 8'h32: s=8'h23; 8'h33: s=8'hc3;
            8'h34: s=8'h18; 8'h35: s=8'h96; 8'h36: s=8'h05; 8'h37: s=8'h9a;
            8'h38: s=8'h07; 8'h39: s=8'h12; 8'h3a: s=8'h80; 8'h3b: s=8'he2;
            8'h3c: s=8'heb; 8'h3d: s=8'h27; 8'h3e: s=8'hb2; 8'h3f: s=8'h75;
            8'h40: s=8'h09; 8'h41: s=8'h83; 8'h42: s=8'h2c; 8'h43: s=8'h1a;
            8'h44: s=8'h1b; 8'h45: s=8'h6e; 8'h46: s=8'h5a; 8'h47: s=8'ha0;
            8'h48: s=8'h52; 8'h49: s=8'h3b; 8'h4a: s=8'hd6; 8'h4b: s=8'hb3;
            8'h4c: s=8'h29; 8'h4d: s=8'he3; 8'h4e: s=8'h2f; 8'h4f: s=8'h84;
            8'h50: s=8'h53; 8'h51: s=8'hd1; 8'h52: s=8'h00; 8'h53: s=8'hed;
            8'h54: s=8'h20; 8'h55: s=8'hfc; 8'h56: s=8'hb1; 8'h57: s=8'h5b;
            8'h58: s=8'h6a; 8'h59: s=8'hcb; 8'h5a: s=8'hbe; 8'h5b: s=8'h39;
            8'h5c: s=8'h4a; 8'h5d: s=8'h4c; 8'h5e: s=8'h58; 8'h5f: s=8'hcf;
            8'h60: s=8'hd0; 8'h61: s=8'hef; 8'h62: s=8'haa; 8'h63: s=8'hfb;
            8'h64: s=8'h43; 8'h65: s=8'h4d; 8'h66: s=8'h33; 8'h67: s=8'h85;
            8'h68: s=8'h45; 8'h69: s=8'hf9; 8'h6a: s=8'h02; 8'h6b: s=8'h7f;
            8'h6c: s=8'h50; 8'h6d: s=8'h3c; 8'h6e: s=8'h9f; 8'h6f: s=8'ha8;
            8'h70: s=8'h51; 8'h71: s=8'ha3; 8'h72: s=8'h40; 8'h73: s=8'h8f;
            8'h74: s=8'h92; 8'h75: s=8'h9d; 8'h76: s=8'h38; 8'h77: s=8'hf5;
            8'h78: s=8'hbc; 8'h79: s=8'hb6; 8'h7a: s=8'hda; 8'h7b: s=8'h21;
            8'h7c: s=8'h10; 8'h7d: s=8'hff; 8'h7e: s=8'hf3; 8'h7f: s=8'hd2;
            8'h80: s=8'hcd; 8'h81: s=8'h0c; 8'h82: s=8'h13; 8'h83: s=8'hec;
            8'h84: s=8'h5f; 8'h85: s=8'h97; 8'h86: s=8'h44; 8'h87: s=8'h17;
            8'h88: s=8'hc4; 8'h89: s=8'ha7; 8'h8a: s=8'h7e; 8'h8b: s=8'h3d;
            8'h8c: s=8'h64; 8'h8d: s=8'h5d; 8'h8e: s=8'h19; 8'h8f: s=8'h73;
            8'h90: s=8'h60; 8'h91: s=8'h81; 8'h92: s=8'h4f; 8'h93: s=8'hdc;
            8'h94: s=8'h22; 8'h95: s=8'h2a; 8'h96: s=8'h90; 8'h97: s=8'h88;
            8'h98: s=8'h46; 8'h99: s=8'hee; 8'h9a: s=8'hb8; 8'h9b: s=8'h14;
            8'h9c: s=8'hde; 8'h9d: s=8'h5e; 8'h9e: s=8'h0b; 8'h9f: s=8'hdb;
            8'ha0: s=8'he0; 8'ha1: s=8'h32; 8'ha2: s=8'h3a; 8'ha3: s=8'h0a;
            8'ha4: s=8'h49; 8'ha5: s=8'h06; 8'ha6: s=8'h24; 8'ha7: s=8'h5c;
            8'ha8: s=8'hc2; 8'ha9: s=8'hd3; 8'haa: s=8'hac; 8'hab: s=8'h62;
            8'hac: s=8'h91; 8'had: s=8'h95; 8'hae: s=8'he4; 8'haf: s=8'h79;
            8'hb0: s=8'he7; 8'hb1: s=8'hc8; 8'hb2: s=8'h37; 8'hb3: s=8'h6d;
            8'hb4: s=8'h8d; 8'hb5: s=8'hd5; 8'hb6: s=8'h4e; 8'hb7: s=8'ha9;
            8'hb8: s=8'h6c; 8'hb9: s=8'h56; 8'hba: s=8'hf4; 8'hbb: s=8'hea;
            8'hbc: s=8'h65; 8'hbd: s=8'h7a; 8'hbe: s=8'hae; 8'hbf: s=8'h08;
            8'hc0: s=8'hba; 8'hc1: s=8'h78; 8'hc2: s=8'h25; 8'hc3: s=8'h2e;
            8'hc4: s=8'h1c; 8'hc5: s=8'ha6; 8'hc6: s=8'hb4; 8'hc7: s=8'hc6;
            8'hc8: s=8'he8; 8'hc9: s=8'hdd; 8'hca: s=8'h74; 8'hcb: s=8'h1f;
            8'hcc: s=8'h4b; 8'hcd: s=8'hbd; 8'hce: s=8'h8b; 8'hcf: s=8'h8a;
            8'hd0: s=8'h70; 8'hd1: s=8'h3e; 8'hd2: s=8'hb5; 8'hd3: s=8'h66;
            8'hd4: s=8'h48; 8'hd5: s=8'h03; 8'hd6: s=8'hf6; 8'hd7: s=8'h0e;
            8'hd8: s=8'h61; 8'hd9: s=8'h35; 8'hda: s=8'h57; 8'hdb: s=8'hb9;
            8'hdc: s=8'h86; 8'hdd: s=8'hc1; 8'hde: s=8'h1d; 8'hdf: s=8'h9e;
            8'he0: s=8'he1; 8'he1: s=8'hf8; 8'he2: s=8'h98; 8'he3: s=8'h11;
            8'he4: s=8'h69; 8'he5: s=8'hd9; 8'he6: s=8'h8e; 8'he7: s=8'h94;
            8'he8: s=8'h9b; 8'he9: s=8'h1e; 8'hea: s=8'h87; 8'heb: s=8'he9;
            8'hec: s=8'hce; 8'hed: s=8'h55; 8'hee: s=8'h28; 8'hef: s=8'hdf;
            8'hf0: s=8'h8c; 8'hf1: s=8'ha1; 8'hf2: s=8'h89; 8'hf3: s=8'h0d;
            8'hf4: s=8'hbf; 8'hf5: s=8'he6; 8'hf6: s=8'h42; 8'hf7: s=8'h68;
            8'hf8: s=8'h41; 8'hf9: s=8'h99; 8'hfa: s=8'h2d; 8'hfb: s=8'h0f;
            8'hfc: s=8'hb0; 8'hfd: s=8'h54; 8'hfe: s=8'hbb; 8'hff: s=8'h16;
            default: s=8'h00;
        endcase
        sbox = s;
    endfunction

    function automatic logic [7:0] rcon(input logic [3:0] r);
        logic [7:0] v;
        unique case (r)
            4'd1: v = 8'h01; 4'd2: v = 8'h02; 4'd3: v = 8'h04; 4'd4: v = 8'h08;
            4'd5: v = 8'h10; 4'd6: v = 8'h20; 4'd7: v = 8'h40; 4'd8: v = 8'h80;
            4'd9: v = 8'h1b; 4'd10: v = 8'h36;
            default: v = 8'h00;
        endcase
        rcon = v;
    endfunction

    // One AES round without key add; mix selects MixColumns.
    function automatic blk_t aes_round(input blk_t s, input logic mix);
        blk_t t, o;
        logic [7:0] a0, a1, a2, a3;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[8*(r+4*c) +: 8] = sbox(s[8*(r+4*((c+r)%4)) +: 8]);
            end
        end
        o = t;
        if (mix) begin
            for (int c = 0; c < 4; c++) begin
                a0 = t[8*(4*c) +: 8];   a1 = t[8*(4*c+1) +: 8];
                a2 = t[8*(4*c+2) +: 8]; a3 = t[8*(4*c+3) +: 8];
                o[8*(4*c) +: 8]   = gf_dbl(a0) ^ gf_dbl(a1) ^ a1 ^ a2 ^ a3;
                o[8*(4*c+1) +: 8] = a0 ^ gf_dbl(a1) ^ gf_dbl(a2) ^ a2 ^ a3;
                o[8*(4*c+2) +: 8] = a0 ^ a1 ^ gf_dbl(a2) ^ gf_dbl(a3) ^ a3;
                o[8*(4*c+3) +: 8] = gf_dbl(a0) ^ a0 ^ a1 ^ a2 ^ gf_dbl(a3);
            end
        end
        aes_round = o;
    endfunction

    // Next AES-128 round key from the previous one.
    function automatic blk_t key_step(input blk_t k, input logic [3:0] r);
        blk_t n;
        logic [31:0] t;
        t = {sbox(k[103:96]), sbox(k[127:120]), sbox(k[119:112]),
             sbox(k[111:104]) ^ rcon(r)};
        n[31:0]   = k[31:0] ^ t;
        n[63:32]  = k[63:32] ^ n[31:0];
        n[95:64]  = k[95:64] ^ n[63:32];
        n[127:96] = k[127:96] ^ n[95:64];
        key_step = n;
    endfunction

endpackage
`default_nettype wire

/* src/aes_round_counter_mac_core.sv */
`default_nettype none
// Counter-mode round MAC on AES rounds. One 128-bit block is accepted per
// cycle: for block i the counter block (i in bytes 0..7) runs HASH_ROUNDS
// AES rounds under key 1, the message is XORed in, MIX_ROUNDS keyless
// rounds follow and the result is folded into a 128-bit accumulator. A
// request flagged tlast produces a tag, full AES-128 of the accumulator
// under key 2, after which accumulator and counter restart at zero. Each
// round is one cell of a register chain with its round key computed in
// the same cell. The accumulator takes a block once it has passed every
// hash-chain cell, and its tag then runs through the final AES chain and
// the output register. Throughput is one block per cycle; the whole chain
// advances together and stalls only while a tag waits at the output.
// Keys are to be written over the cfg port only while idle; the core does not enforce this.
module aes_round_counter_mac_core #(
    parameter int unsigned HASH_ROUNDS = 6,
    parameter int unsigned MIX_ROUNDS  = 4
) (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_tvalid,
    output logic         s_tready,
    input  wire  [127:0] s_tdata,   // block_low[63:0], block_high[127:64]
    input  wire          s_tlast,   // last_block
    output logic         m_tvalid,
    input  wire          m_tready,
    output logic [127:0] m_tdata,   // tag_low[63:0], tag_high[127:64]
    input  wire          cfg_valid,
    output logic         cfg_ready,
    input  wire  [1:0]   cfg_index,
    input  wire  [63:0]  cfg_data
);
    import arcm_pkg::*;

    localparam int unsigned NH = HASH_ROUNDS + MIX_ROUNDS;

    logic [63:0] key1_lo_reg, key1_hi_reg, key2_lo_reg, key2_hi_reg;
    logic [63:0] ctr_reg;
    blk_t        acc_reg;
    logic        en;

    // Chain advances unless the output holds an untaken tag.
    assign en        = !m_tvalid || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key1_lo_reg <= '0; key1_hi_reg <= '0;
            key2_lo_reg <= '0; key2_hi_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_KEY1_LOW:  key1_lo_reg <= cfg_data;
                REG_KEY1_HIGH: key1_hi_reg <= cfg_data;
                REG_KEY2_LOW:  key2_lo_reg <= cfg_data;
                REG_KEY2_HIGH: key2_hi_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Hash chain: cells 1..NH; side carries the message until it is mixed.
    logic h_vld [0:NH];
    logic h_aux [0:NH];
    blk_t h_dat [0:NH];
    blk_t h_key [0:NH];
    blk_t h_sid [0:NH];
    blk_t k1;

    assign k1       = {key1_hi_reg, key1_lo_reg};
    assign h_vld[0] = s_tvalid && s_tready;
    assign h_aux[0] = s_tlast;
    assign h_dat[0] = {64'd0, ctr_reg} ^ k1;
    assign h_key[0] = k1;
    assign h_sid[0] = s_tdata;

    for (genvar j = 1; j <= NH; j++) begin : g_hash
        blk_t din;
        // The message joins right after the last keyed round.
        if (j == HASH_ROUNDS + 1) begin : g_join
            assign din = h_dat[j-1] ^ h_sid[j-1];
        end else begin : g_pass
            assign din = h_dat[j-1];
        end
        arcm_cell #(
            .ROUND   (j <= HASH_ROUNDS ? j : 1),
            .MIX     (j != HASH_ROUNDS && j != NH),
            .USE_KEY (j <= HASH_ROUNDS)
        ) u_cell (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .vld_in(h_vld[j-1]), .aux_in(h_aux[j-1]),
            .data_in(din), .key_in(h_key[j-1]), .side_in(h_sid[j-1]),
            .vld_out(h_vld[j]), .aux_out(h_aux[j]), .data_out(h_dat[j]),
            .key_out(h_key[j]), .side_out(h_sid[j])
        );
    end

    // Counter and accumulator.
    blk_t acc_sum;
    assign acc_sum = acc_reg ^ h_dat[NH];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctr_reg <= '0;
            acc_reg <= '0;
        end else begin
            if (h_vld[0]) begin
                ctr_reg <= s_tlast ? 64'd0 : ctr_reg + 64'd1;
            end
            if (en && h_vld[NH]) begin
                acc_reg <= h_aux[NH] ? '0 : acc_sum;
            end
        end
    end

    // Final AES-128 chain, fed only by last blocks.
    logic f_vld [0:FINAL_ROUNDS];
    logic f_aux [0:FINAL_ROUNDS];
    blk_t f_dat [0:FINAL_ROUNDS];
    blk_t f_key [0:FINAL_ROUNDS];
    blk_t f_sid [0:FINAL_ROUNDS];
    blk_t k2;

    assign k2       = {key2_hi_reg, key2_lo_reg};
    assign f_vld[0] = h_vld[NH] && h_aux[NH];
    assign f_aux[0] = 1'b1;
    assign f_dat[0] = acc_sum ^ k2;
    assign f_key[0] = k2;
    assign f_sid[0] = '0;

    for (genvar j = 1; j <= FINAL_ROUNDS; j++) begin : g_fin
        arcm_cell #(
            .ROUND   (j),
            .MIX     (j != FINAL_ROUNDS),
            .USE_KEY (1'b1)
        ) u_cell (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .vld_in(f_vld[j-1]), .aux_in(f_aux[j-1]),
            .data_in(f_dat[j-1]), .key_in(f_key[j-1]), .side_in(f_sid[j-1]),
            .vld_out(f_vld[j]), .aux_out(f_aux[j]), .data_out(f_dat[j]),
            .key_out(f_key[j]), .side_out(f_sid[j])
        );
    end

    // Output register: the tag waits here while the chain holds.
    logic   out_vld_reg;
    blk_t   out_dat_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (en) begin
            out_vld_reg <= f_vld[FINAL_ROUNDS] && f_aux[FINAL_ROUNDS]
                           && (f_sid[FINAL_ROUNDS] == '0);
        end
        if (en) begin
            out_dat_reg <= f_dat[FINAL_ROUNDS];
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_dat_reg;
endmodule
`default_nettype wire

/* src/arcm_cell.sv */
`default_nettype none
module arcm_cell #(
    parameter int unsigned ROUND = 1,
    parameter bit          MIX   = 1'b1,
    parameter bit          USE_KEY = 1'b1
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  en,
    input  wire                  vld_in,
    input  wire                  aux_in,
    input  wire arcm_pkg::blk_t  data_in,
    input  wire arcm_pkg::blk_t  key_in,
    input  wire arcm_pkg::blk_t  side_in,
    output logic                 vld_out,
    output logic                 aux_out,
    output arcm_pkg::blk_t       data_out,
    output arcm_pkg::blk_t       key_out,
    output arcm_pkg::blk_t       side_out
);
    import arcm_pkg::*;

    // One pipeline cell: a round on the data, one step of the key
    // schedule travelling alongside, and a side word carried along.
    blk_t data_reg, key_reg, side_reg, key_nx;
    logic vld_reg, aux_reg;

    assign key_nx = USE_KEY ? key_step(key_in, 4'(ROUND)) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= vld_in;
        end
        if (en) begin
            aux_reg  <= aux_in;
            data_reg <= aes_round(data_in, MIX) ^ key_nx;
            key_reg  <= key_nx;
            side_reg <= side_in;
        end
    end

    assign vld_out  = vld_reg;
    assign aux_out  = aux_reg;
    assign data_out = data_reg;
    assign key_out  = key_reg;
    assign side_out = side_reg;
endmodule
`default_nettype wire

/* src/arcm_checker.sv */
`default_nettype none
module arcm_checker (
    input wire         aclk,
    input wire         aresetn,
    input wire         s_tvalid,
    input wire         s_tready,
    input wire         m_tvalid,
    input wire         m_tready,
    input wire [127:0] m_tdata
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("tag dropped or changed under stall");

    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while tag stalled");

    a_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");

    a_rst: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !m_tvalid)
        else $error("tag valid right after reset");
endmodule

bind aes_round_counter_mac_core arcm_checker u_arcm_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire

/* bench/aes_round_counter_mac_core_test.sv */
`timescale 1ns / 100ps
`default_nettype none
// Bench for the AES round counter MAC core. Blocks stream in on the s_ side,
// tags come back on the m_ side. The predictor below recomputes every tag from
// the blocks it sees accepted, with its own AES round, key schedule and S-box.
module aes_round_counter_mac_core_test;
    import arcm_pkg::*;

    localparam int HASH_N = 6;
    localparam int MIX_N  = 4;
    localparam int LATENCY = HASH_N + MIX_N + 1 + 10;
    localparam longint LIMIT = 2000000;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    wire          s_tready;
    logic [127:0] s_tdata = '0;   // block_low[63:0], block_high[127:64]
    logic         s_tlast = 1'b0; // last_block
    wire          m_tvalid;
    logic         m_tready = 1'b0;
    wire  [127:0] m_tdata;        // tag_low[63:0], tag_high[127:64]
    logic         cfg_valid = 1'b0;
    wire          cfg_ready;
    logic [1:0]   cfg_index = '0;
    logic [63:0]  cfg_data = '0;

    aes_round_counter_mac_core #(.HASH_ROUNDS(HASH_N), .MIX_ROUNDS(MIX_N)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #4 aclk = ~aclk;

    typedef struct packed {
        logic         last;
        logic [127:0] blk;
    } block_req_t;

    block_req_t   block_q[$];   // requests waiting for the driver
    logic [127:0] tag_q[$];     // tags the predictor expects

    // predictor state
    logic [63:0]  key1_lo, key1_hi, key2_lo, key2_hi;
    logic [127:0] mac_acc;
    logic [63:0]  blk_count;

    int  errors = 0;
    int  send_idle = 7, recv_idle = 77;   // percent
    longint cycles = 0;

    // --- AES pieces, computed from field arithmetic ---
    function automatic logic [7:0] ff_mul(logic [7:0] a, logic [7:0] b);
        logic [7:0] p;
        p = 0;
        for (int k = 0; k < 8; k++) begin
            if (b[0]) p ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
            b = b >> 1;
        end
        return p;
    endfunction

    function automatic logic [7:0] subst(logic [7:0] x);
        logic [7:0] r, b;
        r = 8'h01;
        b = x;
        for (int e = 254; e != 0; e = e >> 1) begin
            if (e & 1) r = ff_mul(r, b);
            b = ff_mul(b, b);
        end
        return r ^ {r[6:0], r[7]} ^ {r[5:0], r[7:6]} ^ {r[4:0], r[7:5]}
               ^ {r[3:0], r[7:4]} ^ 8'h63;
    endfunction

    function automatic logic [7:0] xt(logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [127:0] one_round(logic [127:0] s, logic mix, logic [127:0] rk);
        logic [127:0] t, o;
        logic [7:0] a0, a1, a2, a3;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[8*(r+4*c) +: 8] = subst(s[8*(r+4*((c+r)%4)) +: 8]);
        o = t;
        if (mix) begin
            for (int c = 0; c < 4; c++) begin
                a0 = t[32*c +: 8];    a1 = t[32*c+8 +: 8];
                a2 = t[32*c+16 +: 8]; a3 = t[32*c+24 +: 8];
                o[32*c +: 8]    = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
                o[32*c+8 +: 8]  = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
                o[32*c+16 +: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
                o[32*c+24 +: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
            end
        end
        return o ^ rk;
    endfunction

    function automatic logic [127:0] next_key(logic [127:0] k, logic [7:0] rc);
        logic [127:0] n;
        logic [31:0] t;
        t = {subst(k[103:96]), subst(k[127:120]), subst(k[119:112]),
             subst(k[111:104]) ^ rc};
        n[31:0]   = k[31:0] ^ t;
        n[63:32]  = k[63:32] ^ n[31:0];
        n[95:64]  = k[95:64] ^ n[63:32];
        n[127:96] = k[127:96] ^ n[95:64];
        return n;
    endfunction

    // nrounds AES rounds; keyed=0 means all-zero round keys
    function automatic logic [127:0] cipher(logic [127:0] s, logic [127:0] key,
                                            int nrounds, logic keyed);
        logic [127:0] rk;
        logic [7:0] rc;
        rk = keyed ? key : '0;
        rc = 8'h01;
        s ^= rk;
        for (int j = 1; j <= nrounds; j++) begin
            if (keyed) begin
                rk = next_key(rk, rc);
                rc = xt(rc);
            end
            s = one_round(s, j != nrounds, rk);
        end
        return s;
    endfunction

    // Fold one accepted block into the MAC; queue a tag on the last one.
    task automatic absorb_block(block_req_t rq);
        logic [127:0] c;
        c = cipher({64'd0, blk_count}, {key1_hi, key1_lo}, HASH_N, 1'b1);
        c = cipher(c ^ rq.blk, '0, MIX_N, 1'b0);
        mac_acc ^= c;
        blk_count++;
        if (rq.last) begin
            tag_q.push_back(cipher(mac_acc, {key2_hi, key2_lo}, 10, 1'b1));
            mac_acc = '0;
            blk_count = '0;
        end
    endtask

    // --- driver ---
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                absorb_block('{last: s_tlast, blk: s_tdata});
                void'(block_q.pop_front());
            end
            if (block_q.size() > (s_tvalid && s_tready ? 0 : 0) &&
                    $urandom_range(99) >= send_idle) begin
                s_tvalid <= 1'b1;
                s_tdata  <= block_q[0].blk;
                s_tlast  <= block_q[0].last;
            end else if (!(s_tvalid && !s_tready)) begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // --- monitor ---
    logic [127:0] want;
    always @(posedge aclk) begin
        cycles++;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (tag_q.size() == 0) begin
                    $error("unexpected tag %h", m_tdata);
                    errors++;
                end else begin
                    want = tag_q.pop_front();
                    if (m_tdata[63:0] !== want[63:0]) begin
                        $error("tag_low exp %h got %h", want[63:0], m_tdata[63:0]);
                        errors++;
                    end
                    if (m_tdata[127:64] !== want[127:64]) begin
                        $error("tag_high exp %h got %h", want[127:64], m_tdata[127:64]);
                        errors++;
                    end
                end
            end
            m_tready <= $urandom_range(99) >= recv_idle;
        end
        if (cycles > LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [63:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_KEY1_LOW:  key1_lo = val;
            REG_KEY1_HIGH: key1_hi = val;
            REG_KEY2_LOW:  key2_lo = val;
            default:       key2_hi = val;
        endcase
    endtask

    // Wait for the queued blocks and tags to drain, then let the pipe empty.
    task automatic drain();
        while (block_q.size() != 0 || s_tvalid || tag_q.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    task automatic push_block(logic [63:0] lo, logic [63:0] hi, logic last);
        block_q.push_back('{last: last, blk: {hi, lo}});
    endtask

    function automatic logic [63:0] rnd64();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial begin
        int msg_len;
        key1_lo = 0; key1_hi = 0; key2_lo = 0; key2_hi = 0;
        mac_acc = '0;
        blk_count = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: reset keys, single-block messages at field extremes and a byte-count pattern.
        push_block('0, '0, 1'b1);
        push_block('1, '1, 1'b1);
        push_block(64'h0706050403020100, 64'h0f0e0d0c0b0a0908, 1'b1);
        // multi-block message, then another one to confirm clearing
        for (int i = 0; i < 5; i++) push_block(rnd64(), rnd64(), i == 4);
        for (int i = 0; i < 3; i++) push_block('1, '0, i == 2);
        drain();

        // All-ones keys, an extreme setting.
        write_reg(REG_KEY1_LOW, '1);
        write_reg(REG_KEY1_HIGH, '1);
        write_reg(REG_KEY2_LOW, '1);
        write_reg(REG_KEY2_HIGH, '1);
        push_block('0, '1, 1'b1);
        for (int i = 0; i < 6; i++) push_block('1, '1, i == 5);
        drain();

        // Random phases, each with fresh keys; the idling mix changes at phases 2 and 4.
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 2) begin send_idle = 77; recv_idle = 7; end
            if (ph == 4) begin send_idle = 0;  recv_idle = 0; end
            write_reg(REG_KEY1_LOW, rnd64());
            write_reg(REG_KEY1_HIGH, rnd64());
            write_reg(REG_KEY2_LOW, rnd64());
            write_reg(REG_KEY2_HIGH, rnd64());
            for (int n = 0; n < 300; n += msg_len) begin
                msg_len = ($urandom_range(9) == 0) ? $urandom_range(20, 40)
                                                   : $urandom_range(1, 8);
                for (int i = 0; i < msg_len; i++)
                    push_block(rnd64(), rnd64(), i == msg_len - 1);
                // in phase 1, after the first message, hold off until the pipe has delivered every tag
                if (n == 0 && ph == 1)
                    while (block_q.size() != 0 || s_tvalid || tag_q.size() != 0)
                        @(posedge aclk);
            end
            drain();
        end

        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire

/* sim.f */
src/arcm_pkg.sv
src/arcm_cell.sv
src/aes_round_counter_mac_core.sv
src/arcm_checker.sv
bench/aes_round_counter_mac_core_test.sv
